### src/ntr_pkg.sv
package ntr_pkg;

    localparam int OFFSET_BITS = 16;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef logic [OFFSET_BITS-1:0] offset_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EXP_L = 8'h65;
    localparam logic [7:0] CH_EXP_U = 8'h45;

    localparam logic [1:0] TK_NONE  = 2'd0;
    localparam logic [1:0] TK_INT   = 2'd1;
    localparam logic [1:0] TK_FLOAT = 2'd2;

    typedef enum logic [2:0] {
        CC_ZERO,
        CC_DIGIT,
        CC_DOT,
        CC_EXPO,
        CC_SIGN,
        CC_OTHER,
        CC_END
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic        scan_start;
        offset_t     start_offset;
    } queue_entry_t;

endpackage

### src/ntr_char_if.sv
interface ntr_char_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_code;
    logic        scan_start;
    logic [15:0] start_offset;
    logic        text_end;

    modport source (output valid, output char_code, output scan_start,
                    output start_offset, output text_end, input ready);
    modport sink   (input valid, input char_code, input scan_start,
                    input start_offset, input text_end, output ready);
endinterface

### src/ntr_token_if.sv
interface ntr_token_if;
    logic        valid;
    logic        ready;
    logic [1:0]  token_kind;
    logic [15:0] token_begin;
    logic [15:0] token_end;

    modport source (output valid, output token_kind, output token_begin,
                    output token_end, input ready);
    modport sink   (input valid, input token_kind, input token_begin,
                    input token_end, output ready);
endinterface

### src/number_token_recognizer.sv
// Throughput: one character transfer per cycle, sustained while the token receiver
// takes results; an untaken result stalls the queue, and a full queue stalls the input.
// Path: the result of a scan passes through the 4-entry queue and then the result
// register after the transfer of the character or end mark that closes it.
// Reset: rst_n clears the queue, the scan state and the result register;
// the block takes characters from the first cycle after reset.
module number_token_recognizer (
    input  logic        clk,
    input  logic        rst_n,
    ntr_char_if.sink    chars,
    ntr_token_if.source tokens
);

    logic                  push_valid, push_ready;
    logic                  pop_valid, pop_ready;
    ntr_pkg::queue_entry_t push_entry, pop_entry;

    ntr_front u_front (
        .chars      (chars),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    ntr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    ntr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .tokens    (tokens)
    );

endmodule

### src/ntr_front.sv
module ntr_front (
    ntr_char_if.sink              chars,
    output logic                  push_valid,
    input  logic                  push_ready,
    output ntr_pkg::queue_entry_t push_entry
);

    ntr_pkg::char_class_t cls;

    always_comb
    begin
        if (chars.text_end)
            cls = ntr_pkg::CC_END;
        else if (chars.char_code == ntr_pkg::CH_ZERO)
            cls = ntr_pkg::CC_ZERO;
        else if (chars.char_code > ntr_pkg::CH_ZERO && chars.char_code <= ntr_pkg::CH_NINE)
            cls = ntr_pkg::CC_DIGIT;
        else if (chars.char_code == ntr_pkg::CH_DOT)
            cls = ntr_pkg::CC_DOT;
        else if (chars.char_code == ntr_pkg::CH_EXP_L || chars.char_code == ntr_pkg::CH_EXP_U)
            cls = ntr_pkg::CC_EXPO;
        else if (chars.char_code == ntr_pkg::CH_PLUS || chars.char_code == ntr_pkg::CH_MINUS)
            cls = ntr_pkg::CC_SIGN;
        else
            cls = ntr_pkg::CC_OTHER;
    end

    assign push_valid              = chars.valid;
    assign chars.ready             = push_ready;
    assign push_entry.cls          = cls;
    assign push_entry.scan_start   = chars.scan_start;
    assign push_entry.start_offset = ntr_pkg::offset_t'(chars.start_offset);

endmodule

### src/ntr_queue.sv
module ntr_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  ntr_pkg::queue_entry_t push_entry,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output ntr_pkg::queue_entry_t pop_entry
);

    ntr_pkg::queue_entry_t mem [ntr_pkg::QUEUE_DEPTH];

    logic [ntr_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ntr_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ntr_pkg::QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign push_ready = count_reg != ntr_pkg::QUEUE_CNT_BITS'(ntr_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/ntr_back.sv
module ntr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  ntr_pkg::queue_entry_t pop_entry,
    ntr_token_if.source           tokens
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_SIGN,
        PH_INT,
        PH_ZERO,
        PH_DOT,
        PH_FRAC,
        PH_EXP,
        PH_EXPSIGN,
        PH_EXPDIGITS
    } phase_t;

    phase_t           phase_reg, phase_next;
    phase_t           ph_cur, ph_adv;
    ntr_pkg::offset_t begin_reg, begin_next;
    ntr_pkg::offset_t cursor_reg, cursor_next;
    logic             seen_reg, seen_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       kind_reg, kind_next;
    logic [15:0]      tbegin_reg, tbegin_next;
    logic [15:0]      tend_reg, tend_next;
    logic             take;
    logic             active;
    logic             complete;
    ntr_pkg::offset_t beg_cur, cur_cur;
    logic             seen_cur;

    assign pop_ready = !out_valid_reg || tokens.ready;
    assign take      = pop_valid && pop_ready;

    always_comb
    begin
        if (pop_entry.scan_start)
        begin
            ph_cur   = PH_START;
            beg_cur  = pop_entry.start_offset;
            cur_cur  = pop_entry.start_offset;
            seen_cur = 1'b0;
        end
        else
        begin
            ph_cur   = phase_reg;
            beg_cur  = begin_reg;
            cur_cur  = cursor_reg;
            seen_cur = seen_reg;
        end
        active = ph_cur != PH_IDLE;
    end

    // next phase, idle when the character cannot extend the number
    always_comb
    begin
        ph_adv = PH_IDLE;
        unique case (ph_cur)
            PH_START:
            begin
                unique case (pop_entry.cls)
                    ntr_pkg::CC_SIGN:  ph_adv = PH_SIGN;
                    ntr_pkg::CC_ZERO:  ph_adv = PH_ZERO;
                    ntr_pkg::CC_DIGIT: ph_adv = PH_INT;
                    default:           ph_adv = PH_IDLE;
                endcase
            end
            PH_SIGN:
            begin
                unique case (pop_entry.cls)
                    ntr_pkg::CC_ZERO:  ph_adv = PH_ZERO;
                    ntr_pkg::CC_DIGIT: ph_adv = PH_INT;
                    default:           ph_adv = PH_IDLE;
                endcase
            end
            PH_INT:
            begin
                unique case (pop_entry.cls) inside
                    ntr_pkg::CC_ZERO, ntr_pkg::CC_DIGIT: ph_adv = PH_INT;
                    ntr_pkg::CC_DOT:                     ph_adv = PH_DOT;
                    ntr_pkg::CC_EXPO:                    ph_adv = PH_EXP;
                    default:                             ph_adv = PH_IDLE;
                endcase
            end
            PH_ZERO:
            begin
                unique case (pop_entry.cls)
                    ntr_pkg::CC_DOT:  ph_adv = PH_DOT;
                    ntr_pkg::CC_EXPO: ph_adv = PH_EXP;
                    default:          ph_adv = PH_IDLE;
                endcase
            end
            PH_DOT:
            begin
                unique case (pop_entry.cls) inside
                    ntr_pkg::CC_ZERO, ntr_pkg::CC_DIGIT: ph_adv = PH_FRAC;
                    default:                             ph_adv = PH_IDLE;
                endcase
            end
            PH_FRAC:
            begin
                unique case (pop_entry.cls) inside
                    ntr_pkg::CC_ZERO, ntr_pkg::CC_DIGIT: ph_adv = PH_FRAC;
                    ntr_pkg::CC_EXPO:                    ph_adv = PH_EXP;
                    default:                             ph_adv = PH_IDLE;
                endcase
            end
            PH_EXP:
            begin
                unique case (pop_entry.cls) inside
                    ntr_pkg::CC_SIGN:                    ph_adv = PH_EXPSIGN;
                    ntr_pkg::CC_ZERO, ntr_pkg::CC_DIGIT: ph_adv = PH_EXPDIGITS;
                    default:                             ph_adv = PH_IDLE;
                endcase
            end
            PH_EXPSIGN, PH_EXPDIGITS:
            begin
                unique case (pop_entry.cls) inside
                    ntr_pkg::CC_ZERO, ntr_pkg::CC_DIGIT: ph_adv = PH_EXPDIGITS;
                    default:                             ph_adv = PH_IDLE;
                endcase
            end
            default: ph_adv = PH_IDLE;
        endcase
    end

    assign complete = ph_cur == PH_INT || ph_cur == PH_ZERO ||
                      ph_cur == PH_FRAC || ph_cur == PH_EXPDIGITS;

    always_comb
    begin
        phase_next     = phase_reg;
        begin_next     = begin_reg;
        cursor_next    = cursor_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && !tokens.ready;
        kind_next      = kind_reg;
        tbegin_next    = tbegin_reg;
        tend_next      = tend_reg;
        if (take && active)
        begin
            begin_next = beg_cur;
            if (ph_adv != PH_IDLE)
            begin
                phase_next  = ph_adv;
                cursor_next = cur_cur + ntr_pkg::offset_t'(1);
                seen_next   = seen_cur || ph_adv == PH_DOT || ph_adv == PH_EXP;
            end
            else
            begin
                phase_next     = PH_IDLE;
                cursor_next    = cur_cur;
                seen_next      = seen_cur;
                out_valid_next = 1'b1;
                tbegin_next    = 16'(beg_cur);
                if (complete)
                begin
                    kind_next = seen_cur ? ntr_pkg::TK_FLOAT : ntr_pkg::TK_INT;
                    tend_next = 16'(cur_cur);
                end
                else
                begin
                    kind_next = ntr_pkg::TK_NONE;
                    tend_next = 16'(beg_cur);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            begin_reg     <= '0;
            cursor_reg    <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= ntr_pkg::TK_NONE;
            tbegin_reg    <= '0;
            tend_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            begin_reg     <= begin_next;
            cursor_reg    <= cursor_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            tbegin_reg    <= tbegin_next;
            tend_reg      <= tend_next;
        end
    end

    assign tokens.valid       = out_valid_reg;
    assign tokens.token_kind  = kind_reg;
    assign tokens.token_begin = tbegin_reg;
    assign tokens.token_end   = tend_reg;

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (kind_reg == ntr_pkg::TK_NONE || kind_reg == ntr_pkg::TK_INT ||
                           kind_reg == ntr_pkg::TK_FLOAT))
        else $error("illegal token kind");

    a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == ntr_pkg::TK_NONE) |-> tbegin_reg == tend_reg)
        else $error("no-number result with non-empty span");

    a_seen_set: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DOT || phase_reg == PH_FRAC || phase_reg == PH_EXP ||
         phase_reg == PH_EXPSIGN || phase_reg == PH_EXPDIGITS) |-> seen_reg)
        else $error("fraction or exponent phase without seen flag");

    a_seen_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_START || phase_reg == PH_SIGN || phase_reg == PH_INT ||
         phase_reg == PH_ZERO) |-> !seen_reg)
        else $error("integer phase with seen flag set");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !tokens.ready) |=> (out_valid_reg && $stable(tend_reg)))
        else $error("pending result overwritten");

endmodule

### bench/ntr_token_checker.sv
`timescale 1ns / 1ps

module ntr_token_checker
    import ntr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ntr_char_if  chars,
    ntr_token_if tokens,
    output int   fail_count,
    output int   pending
);

    typedef enum logic [3:0] {
        NP_IDLE,
        NP_START,
        NP_SIGN,
        NP_INT,
        NP_ZERO,
        NP_DOT,
        NP_FRAC,
        NP_EXP,
        NP_EXP_SIGN,
        NP_EXP_DIGITS
    } num_phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] first;
        logic [15:0] past;
    } token_t;

    token_t     tokens_due[$];
    num_phase_t phase      = NP_IDLE;
    offset_t    begin_ofs  = '0;
    offset_t    cursor_ofs = '0;
    logic       frac_or_exp = 1'b0;
    int         err_total  = 0;

    assign fail_count = err_total;

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_sign(logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic bit is_expo(logic [7:0] c);
        return c == CH_EXP_L || c == CH_EXP_U;
    endfunction

    function automatic num_phase_t next_phase(num_phase_t ph, logic [7:0] c);
        case (ph)
            NP_START:
            begin
                if (is_sign(c)) return NP_SIGN;
                if (c == CH_ZERO) return NP_ZERO;
                if (is_digit(c)) return NP_INT;
            end
            NP_SIGN:
            begin
                if (c == CH_ZERO) return NP_ZERO;
                if (is_digit(c)) return NP_INT;
            end
            NP_INT, NP_ZERO:
            begin
                if (ph == NP_INT && is_digit(c)) return NP_INT;
                if (c == CH_DOT) return NP_DOT;
                if (is_expo(c)) return NP_EXP;
            end
            NP_DOT:
            begin
                if (is_digit(c)) return NP_FRAC;
            end
            NP_FRAC:
            begin
                if (is_digit(c)) return NP_FRAC;
                if (is_expo(c)) return NP_EXP;
            end
            NP_EXP:
            begin
                if (is_sign(c)) return NP_EXP_SIGN;
                if (is_digit(c)) return NP_EXP_DIGITS;
            end
            NP_EXP_SIGN, NP_EXP_DIGITS:
            begin
                if (is_digit(c)) return NP_EXP_DIGITS;
            end
            default:
            begin
            end
        endcase
        return NP_IDLE;
    endfunction

    function automatic void step_recognizer(logic [7:0] c, logic st, logic [15:0] ofs,
                                            logic te);
        num_phase_t nxt;
        token_t     tok;
        if (st)
        begin
            begin_ofs   = offset_t'(ofs);
            cursor_ofs  = offset_t'(ofs);
            frac_or_exp = 1'b0;
            phase       = NP_START;
        end
        else if (phase == NP_IDLE)
        begin
            return;
        end
        nxt = te ? NP_IDLE : next_phase(phase, c);
        if (nxt != NP_IDLE)
        begin
            if (nxt == NP_DOT || nxt == NP_EXP)
                frac_or_exp = 1'b1;
            phase      = nxt;
            cursor_ofs = cursor_ofs + 1'b1;
            return;
        end
        if (phase inside {NP_INT, NP_ZERO, NP_FRAC, NP_EXP_DIGITS})
        begin
            tok.kind  = frac_or_exp ? TK_FLOAT : TK_INT;
            tok.first = 16'(begin_ofs);
            tok.past  = 16'(cursor_ofs);
        end
        else
        begin
            tok.kind  = TK_NONE;
            tok.first = 16'(begin_ofs);
            tok.past  = 16'(begin_ofs);
        end
        tokens_due.push_back(tok);
        phase = NP_IDLE;
    endfunction

    function automatic void report_failure(string what, token_t want, token_t got);
        err_total++;
        if (err_total <= 10)
            $display("%t: %s: expected kind %0d [%h,%h) got kind %0d [%h,%h)", $realtime,
                     what, want.kind, want.first, want.past, got.kind, got.first, got.past);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        token_t want;
        token_t got;
        if (!rst_n)
        begin
            phase       = NP_IDLE;
            begin_ofs   = '0;
            cursor_ofs  = '0;
            frac_or_exp = 1'b0;
            tokens_due.delete();
            pending <= 0;
        end
        else
        begin
            // results first: a transfer on the input side cannot produce one this edge
            if (tokens.valid && tokens.ready)
            begin
                got = '{tokens.token_kind, tokens.token_begin, tokens.token_end};
                if (tokens_due.size() == 0)
                begin
                    report_failure("unexpected token", '0, got);
                end
                else
                begin
                    want = tokens_due.pop_front();
                    if (got.kind !== want.kind || got.first !== want.first ||
                        got.past !== want.past)
                        report_failure("token mismatch", want, got);
                end
            end
            if (chars.valid && chars.ready)
                step_recognizer(chars.char_code, chars.scan_start, chars.start_offset,
                                chars.text_end);
            pending <= tokens_due.size();
        end
    end

endmodule

### bench/tb_number_token_recognizer.sv
`timescale 1ns / 1ps

module tb_number_token_recognizer;

    import ntr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 300;
    localparam int SETTLE_TICKS = 20;

    typedef logic [7:0] text_t[$];

    logic clk;
    logic rst_n;
    logic rx_hold;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   scan_items;
    int   cycle_count;
    int   fail_count;
    int   pending;

    ntr_char_if  chars ();
    ntr_token_if tokens ();

    number_token_recognizer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars.sink),
        .tokens (tokens.source)
    );

    ntr_token_checker token_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .tokens     (tokens),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        tokens.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);

    task automatic send_char_item(logic [7:0] c, logic st, logic [15:0] ofs, logic te);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            chars.valid <= 1'b0;
            @(posedge clk);
        end
        chars.valid        <= 1'b1;
        chars.char_code    <= c;
        chars.scan_start   <= st;
        chars.start_offset <= ofs;
        chars.text_end     <= te;
        do
            @(posedge clk);
        while (!chars.ready);
    endtask

    // with_end closes the scan with a text end transfer after the characters
    task automatic send_scan(text_t txt, logic [15:0] ofs, bit with_end);
        for (int i = 0; i < txt.size(); i++)
        begin
            send_char_item(txt[i], i == 0, (i == 0) ? ofs : 16'($urandom_range(0, 65535)),
                           1'b0);
            scan_items++;
        end
        if (with_end)
        begin
            send_char_item(8'($urandom_range(0, 255)), txt.size() == 0,
                           (txt.size() == 0) ? ofs : 16'($urandom_range(0, 65535)), 1'b1);
            scan_items++;
        end
    endtask

    task automatic drain_results();
        chars.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic hold_receiver();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
    endtask

    function automatic text_t to_text(string s);
        text_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'($urandom_range(CH_ZERO, CH_NINE));
    endfunction

    // a byte that cannot extend any number
    function automatic logic [7:0] stopper();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= CH_ZERO && c <= CH_NINE) ||
               c inside {CH_DOT, CH_PLUS, CH_MINUS, CH_EXP_L, CH_EXP_U});
        return c;
    endfunction

    function automatic text_t well_formed();
        text_t q;
        int    r;
        r = $urandom_range(0, 5);
        if (r < 2)
            q.push_back(CH_MINUS);
        else if (r == 2)
            q.push_back(CH_PLUS);
        if ($urandom_range(0, 3) == 0)
        begin
            q.push_back(CH_ZERO);
        end
        else
        begin
            q.push_back(8'($urandom_range(CH_ZERO + 1, CH_NINE)));
            repeat ($urandom_range(0, 5)) q.push_back(rand_digit());
        end
        if ($urandom_range(0, 1))
        begin
            q.push_back(CH_DOT);
            repeat ($urandom_range(1, 4)) q.push_back(rand_digit());
        end
        if ($urandom_range(0, 4) < 2)
        begin
            q.push_back($urandom_range(0, 1) ? CH_EXP_L : CH_EXP_U);
            r = $urandom_range(0, 2);
            if (r == 1)
                q.push_back(CH_PLUS);
            else if (r == 2)
                q.push_back(CH_MINUS);
            repeat ($urandom_range(1, 3)) q.push_back(rand_digit());
        end
        return q;
    endfunction

    function automatic text_t scrambled(int len);
        text_t q;
        int    r;
        repeat (len)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                q.push_back(rand_digit());
            else if (r < 50)
                q.push_back(CH_DOT);
            else if (r < 58)
                q.push_back(CH_EXP_L);
            else if (r < 64)
                q.push_back(CH_EXP_U);
            else if (r < 72)
                q.push_back(CH_PLUS);
            else if (r < 80)
                q.push_back(CH_MINUS);
            else
                q.push_back(8'($urandom_range(0, 255)));
        end
        return q;
    endfunction

    function automatic logic [15:0] pick_offset();
        if ($urandom_range(0, 99) < 15)
            return 16'hFFF8 + 16'($urandom_range(0, 7));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic random_scan();
        text_t txt;
        int    r;
        int    tail;
        r = $urandom_range(0, 99);
        if (r >= 90)
        begin
            // stray transfers: ignored, or continuing a scan cut short
            repeat ($urandom_range(1, 3))
                send_char_item(8'($urandom_range(0, 255)), 1'b0,
                               16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            return;
        end
        if (r < 68)
        begin
            txt = well_formed();
        end
        else if (r < 82)
        begin
            txt = scrambled($urandom_range(1, 8));
        end
        else
        begin
            // cut short, the next scan start abandons it
            txt = well_formed();
            while (txt.size() > 1 && $urandom_range(0, 1))
                void'(txt.pop_back());
            send_scan(txt, pick_offset(), 1'b0);
            return;
        end
        tail = $urandom_range(0, 99);
        if (tail < 25)
        begin
            send_scan(txt, pick_offset(), 1'b1);
        end
        else
        begin
            txt.push_back((tail < 85) ? stopper() : 8'($urandom_range(0, 255)));
            send_scan(txt, pick_offset(), 1'b0);
        end
    endtask

    initial
    begin
        text_t txt;
        int    tx_pct[3];
        int    rx_pct[3];
        tx_pct = '{16, 75, 0};
        rx_pct = '{75, 16, 0};
        rst_n              = 1'b0;
        rx_hold            = 1'b0;
        cycle_count        = 0;
        scan_items         = 0;
        tx_idle_pct        = tx_pct[0];
        rx_idle_pct        = rx_pct[0];
        chars.valid        = 1'b0;
        chars.char_code    = 8'h00;
        chars.scan_start   = 1'b0;
        chars.start_offset = 16'h0000;
        chars.text_end     = 1'b0;
        tokens.ready       = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // leading zero stops before a further digit
        send_scan(to_text("05"), 16'h0000, 1'b0);
        // lone sign
        send_scan(to_text("+"), 16'hFFFF, 1'b1);
        // bare dot
        send_scan(to_text("."), 16'h1234, 1'b0);
        // exponent without digits
        send_scan(to_text("1e"), 16'h8000, 1'b1);
        // full float across the offset wrap
        send_scan(to_text("-9.5E+7"), 16'hFFFC, 1'b1);
        // text end on the first transfer
        send_scan(to_text(""), 16'hAAAA, 1'b1);
        // restart mid scan
        send_scan(to_text("1"), 16'h0010, 1'b0);
        send_scan(to_text("2"), 16'h0020, 1'b1);
        // transfer outside any scan
        send_char_item(8'h00, 1'b0, 16'h5555, 1'b0);
        // dot without a digit
        send_scan(to_text("1.x"), 16'h0100, 1'b0);
        txt = to_text("7");
        txt.push_back(8'hFF);
        send_scan(txt, 16'h7FFF, 1'b0);

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = tx_pct[ph];
            rx_idle_pct = rx_pct[ph];
            if (ph != 1)
                hold_receiver();
            while (scan_items < (ph + 1) * PHASE_ITEMS)
                random_scan();
            drain_results();
        end

        repeat (SETTLE_TICKS) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
